### hw/rtl/dqwc_pkg.sv
// Shared types and constants for the dual quadrature wheel counter.
`default_nettype none

package dqwc_pkg;

    // Opcodes as carried in the request's user field.
    localparam logic [2:0] OP_EDGE      = 3'd0;
    localparam logic [2:0] OP_CLR_POS   = 3'd1;
    localparam logic [2:0] OP_WR_DIFF   = 3'd2;
    localparam logic [2:0] OP_LD_TRIG   = 3'd3;
    localparam logic [2:0] OP_CLR_SPEED = 3'd4;

    // Wheel selector codes.
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_PAIR  = 2'd2;

    localparam int COUNT_W   = 16;
    localparam int SPEED_W   = 8;
    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 5 * COUNT_W + 2 * SPEED_W;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_EDGE,
        CMD_CLR_POS,
        CMD_WR_DIFF,
        CMD_LD_TRIG,
        CMD_CLR_SPEED
    } t_kind;

    // A classified request: what to do, on which wheels, in which direction.
    typedef struct packed {
        t_kind               kind;
        logic                sel_left;
        logic                sel_right;
        logic                up;
        logic [COUNT_W-1:0]  value;
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/dqwc_front.sv
// Front end: takes input requests and classifies them into commands.
`default_nettype none

module dqwc_front (
    input  wire logic [2:0]                    i_opcode,
    input  wire logic [1:0]                    i_wheel,
    input  wire logic                          i_sensor,
    input  wire logic                          i_pin_a,
    input  wire logic                          i_pin_b,
    input  wire logic [dqwc_pkg::COUNT_W-1:0]  i_value,
    output dqwc_pkg::t_cmd                     o_cmd
);

    logic single;
    logic left_up;

    always_comb begin
        single  = (i_wheel == dqwc_pkg::SIDE_LEFT) || (i_wheel == dqwc_pkg::SIDE_RIGHT);
        // Left wheel counts up on an A edge with equal levels or a B edge with unequal ones.
        left_up = (i_pin_a == i_pin_b) != i_sensor;

        o_cmd.value     = i_value;
        o_cmd.sel_left  = (i_wheel == dqwc_pkg::SIDE_LEFT);
        o_cmd.sel_right = (i_wheel == dqwc_pkg::SIDE_RIGHT);
        // The right wheel is mounted mirrored.
        o_cmd.up        = left_up ^ (i_wheel == dqwc_pkg::SIDE_RIGHT);
        o_cmd.kind      = dqwc_pkg::CMD_NOP;

        unique case (i_opcode)
            dqwc_pkg::OP_EDGE: begin
                if (single) o_cmd.kind = dqwc_pkg::CMD_EDGE;
            end
            dqwc_pkg::OP_CLR_POS: begin
                if (i_wheel == dqwc_pkg::SIDE_PAIR) begin
                    o_cmd.sel_left  = 1'b1;
                    o_cmd.sel_right = 1'b1;
                    o_cmd.kind      = dqwc_pkg::CMD_CLR_POS;
                end else if (single) begin
                    o_cmd.kind = dqwc_pkg::CMD_CLR_POS;
                end
            end
            dqwc_pkg::OP_WR_DIFF: begin
                o_cmd.kind = dqwc_pkg::CMD_WR_DIFF;
            end
            dqwc_pkg::OP_LD_TRIG: begin
                if (single) o_cmd.kind = dqwc_pkg::CMD_LD_TRIG;
            end
            dqwc_pkg::OP_CLR_SPEED: begin
                if (single) o_cmd.kind = dqwc_pkg::CMD_CLR_SPEED;
            end
            default: begin
                o_cmd.kind = dqwc_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/dqwc_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module dqwc_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  dqwc_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output dqwc_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = $clog2(dqwc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dqwc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(dqwc_pkg::QUEUE_DEPTH);

    dqwc_pkg::t_cmd r_mem [dqwc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        o_full  = (r_count == DEPTH_CNT);
        o_valid = (r_count != '0);
        o_cmd   = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(dqwc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(dqwc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dqwc_back.sv
// Back end: applies commands to the counters and holds the result for output.
`default_nettype none

module dqwc_back #(
    parameter int SPEED_LIMIT = 127
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cmd_valid,
    input  dqwc_pkg::t_cmd                        i_cmd,
    output logic                                  o_cmd_pop,
    output logic                                  o_tvalid,
    input  wire logic                             i_tready,
    output logic [dqwc_pkg::OUT_DATA_W-1:0]       o_tdata
);

    localparam logic signed [dqwc_pkg::SPEED_W-1:0] LIM_HI =
        dqwc_pkg::SPEED_W'(SPEED_LIMIT);
    localparam logic signed [dqwc_pkg::SPEED_W-1:0] LIM_LO =
        dqwc_pkg::SPEED_W'(-SPEED_LIMIT);
    localparam logic signed [dqwc_pkg::SPEED_W-1:0] SPEED_STEP =
        dqwc_pkg::SPEED_W'(1);

    // Counter state doubles as the output register: it only moves on a pop,
    // and a pop only happens when the previous result has been taken.
    logic        [dqwc_pkg::COUNT_W-1:0] r_pos  [2];
    logic        [dqwc_pkg::COUNT_W-1:0] n_pos  [2];
    logic        [dqwc_pkg::COUNT_W-1:0] r_trig [2];
    logic        [dqwc_pkg::COUNT_W-1:0] n_trig [2];
    logic signed [dqwc_pkg::SPEED_W-1:0] r_speed [2];
    logic signed [dqwc_pkg::SPEED_W-1:0] n_speed [2];
    logic        [dqwc_pkg::COUNT_W-1:0] r_diff, n_diff;
    logic                                r_out_valid, n_out_valid;
    logic                                sel [2];

    always_comb begin
        o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_tready);
        n_out_valid = o_cmd_pop ? 1'b1 : (r_out_valid && !i_tready);
        sel[0]      = i_cmd.sel_left;
        sel[1]      = i_cmd.sel_right;
        n_diff      = r_diff;

        for (int w = 0; w < 2; w++) begin
            n_pos[w]   = r_pos[w];
            n_trig[w]  = r_trig[w];
            n_speed[w] = r_speed[w];
            if (o_cmd_pop && sel[w]) begin
                unique case (i_cmd.kind)
                    dqwc_pkg::CMD_EDGE: begin
                        if (i_cmd.up) begin
                            n_pos[w] = r_pos[w] + 1'b1;
                            if (r_speed[w] < LIM_HI) n_speed[w] = r_speed[w] + SPEED_STEP;
                        end else begin
                            n_pos[w] = r_pos[w] - 1'b1;
                            if (r_speed[w] > LIM_LO) n_speed[w] = r_speed[w] - SPEED_STEP;
                        end
                        if (r_trig[w] != '0) n_trig[w] = r_trig[w] - 1'b1;
                    end
                    dqwc_pkg::CMD_CLR_POS:   n_pos[w]   = '0;
                    dqwc_pkg::CMD_LD_TRIG:   n_trig[w]  = i_cmd.value;
                    dqwc_pkg::CMD_CLR_SPEED: n_speed[w] = '0;
                    default: ;
                endcase
            end
        end

        if (o_cmd_pop) begin
            unique case (i_cmd.kind)
                dqwc_pkg::CMD_EDGE: begin
                    // Left counts add to the difference, right counts subtract.
                    if (i_cmd.up ^ i_cmd.sel_right) n_diff = r_diff + 1'b1;
                    else                           n_diff = r_diff - 1'b1;
                end
                dqwc_pkg::CMD_WR_DIFF: n_diff = i_cmd.value;
                default: ;
            endcase
        end

        o_tvalid = r_out_valid;
        o_tdata  = {r_trig[1], r_trig[0], r_speed[1], r_speed[0], r_diff, r_pos[1], r_pos[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_diff      <= '0;
            for (int w = 0; w < 2; w++) begin
                r_pos[w]   <= '0;
                r_trig[w]  <= '0;
                r_speed[w] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_diff      <= n_diff;
            for (int w = 0; w < 2; w++) begin
                r_pos[w]   <= n_pos[w];
                r_trig[w]  <= n_trig[w];
                r_speed[w] <= n_speed[w];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dual_quadrature_wheel_counter.sv
// Top level of the dual quadrature wheel counter with x4 decoding.
//
//  Channel  | Dir | Contents
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | one request: an edge event or a counter command
//  m_axis   | out | one result per request: all counters after the update
//
// A request is classified as it is accepted and written into a two-entry
// command queue; the back end pops one command per clock while m_axis is not
// stalled, so one request per cycle is then sustained. Each result is
// registered in the back end. A stalled m_axis holds its result while the
// queue takes up to two more requests, then s_axis_tready drops.
// Synchronous active-low reset zeroes every counter and empties the queue.
`default_nettype none

module dual_quadrature_wheel_counter #(
    parameter int SPEED_LIMIT = 127
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [1:0] wheel, [2] sensor, [3] pin_a, [4] pin_b, [20:5] value, [23:21] zero
    input  wire logic [dqwc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] opcode
    input  wire logic [dqwc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] position_left, [31:16] position_right, [47:32] wheel_difference,
    // [55:48] speed_left, [63:56] speed_right, [79:64] trigger_left,
    // [95:80] trigger_right
    output logic [dqwc_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    dqwc_pkg::t_cmd front_cmd;
    dqwc_pkg::t_cmd queue_cmd;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;
    logic           push;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    dqwc_front u_front (
        .i_opcode (s_axis_tuser[2:0]),
        .i_wheel  (s_axis_tdata[1:0]),
        .i_sensor (s_axis_tdata[2]),
        .i_pin_a  (s_axis_tdata[3]),
        .i_pin_b  (s_axis_tdata[4]),
        .i_value  (s_axis_tdata[20:5]),
        .o_cmd    (front_cmd)
    );

    dqwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    dqwc_back #(
        .SPEED_LIMIT (SPEED_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the dual quadrature wheel counter: random and directed requests checked per result.
`default_nettype none

module testbench;

    localparam int SPEED_LIMIT = 127;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;

    // The one wheel code that only the difference write accepts.
    localparam logic [1:0] SIDE_NONE = 2'd3;

    // One result item: every counter after the update.
    typedef struct {
        logic [dqwc_pkg::COUNT_W-1:0] position_left;
        logic [dqwc_pkg::COUNT_W-1:0] position_right;
        logic [dqwc_pkg::COUNT_W-1:0] wheel_difference;
        logic [dqwc_pkg::SPEED_W-1:0] speed_left;
        logic [dqwc_pkg::SPEED_W-1:0] speed_right;
        logic [dqwc_pkg::COUNT_W-1:0] trigger_left;
        logic [dqwc_pkg::COUNT_W-1:0] trigger_right;
    } t_counters;

    // Tracks the counters the block should hold and checks every result
    // against the oldest outstanding prediction.
    class counter_tracker;
        logic [dqwc_pkg::COUNT_W-1:0]        position[2];
        logic [dqwc_pkg::COUNT_W-1:0]        difference;
        logic signed [dqwc_pkg::SPEED_W-1:0] speed[2];
        logic [dqwc_pkg::COUNT_W-1:0]        trigger[2];
        t_counters                           expected_counters[$];
        int                                  errors;

        function new();
            position = '{default: '0};
            difference = '0;
            speed = '{default: '0};
            trigger = '{default: '0};
            errors = 0;
        endfunction

        // Applies one accepted request and queues the counters it leaves.
        function void note_request(logic [2:0] op, logic [1:0] wheel, logic sensor,
                                   logic pin_a, logic pin_b,
                                   logic [dqwc_pkg::COUNT_W-1:0] value);
            t_counters after;
            logic      up;
            int        w;
            w = int'(wheel);
            case (op)
                dqwc_pkg::OP_EDGE: begin
                    if (wheel == dqwc_pkg::SIDE_LEFT || wheel == dqwc_pkg::SIDE_RIGHT) begin
                        // Left wheel counts up on an A edge with equal levels or a B
                        // edge with unequal levels; the right wheel is mirrored.
                        up = ((pin_a == pin_b) != sensor);
                        if (wheel == dqwc_pkg::SIDE_RIGHT)
                            up = !up;
                        if (up) begin
                            position[w] = position[w] + 1'b1;
                            difference = (wheel == dqwc_pkg::SIDE_LEFT) ? difference + 1'b1
                                                                        : difference - 1'b1;
                            if (speed[w] < SPEED_LIMIT)
                                speed[w] = speed[w] + dqwc_pkg::SPEED_W'(1);
                        end else begin
                            position[w] = position[w] - 1'b1;
                            difference = (wheel == dqwc_pkg::SIDE_LEFT) ? difference - 1'b1
                                                                        : difference + 1'b1;
                            if (speed[w] > -SPEED_LIMIT)
                                speed[w] = speed[w] - dqwc_pkg::SPEED_W'(1);
                        end
                        if (trigger[w] != '0)
                            trigger[w] = trigger[w] - 1'b1;
                    end
                end
                dqwc_pkg::OP_CLR_POS: begin
                    if (wheel == dqwc_pkg::SIDE_LEFT || wheel == dqwc_pkg::SIDE_RIGHT) begin
                        position[w] = '0;
                    end else if (wheel == dqwc_pkg::SIDE_PAIR) begin
                        position[0] = '0;
                        position[1] = '0;
                    end
                end
                dqwc_pkg::OP_WR_DIFF: difference = value;
                dqwc_pkg::OP_LD_TRIG: begin
                    if (wheel == dqwc_pkg::SIDE_LEFT || wheel == dqwc_pkg::SIDE_RIGHT)
                        trigger[w] = value;
                end
                dqwc_pkg::OP_CLR_SPEED: begin
                    if (wheel == dqwc_pkg::SIDE_LEFT || wheel == dqwc_pkg::SIDE_RIGHT)
                        speed[w] = '0;
                end
                default: ;
            endcase
            after.position_left = position[0];
            after.position_right = position[1];
            after.wheel_difference = difference;
            after.speed_left = speed[0];
            after.speed_right = speed[1];
            after.trigger_left = trigger[0];
            after.trigger_right = trigger[1];
            expected_counters.push_back(after);
        endfunction

        function void compare(string field, int expected_val, int actual_val);
            if (expected_val != actual_val) begin
                $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
                errors++;
            end
        endfunction

        // Checks one accepted result word against the oldest prediction.
        function void check_counters(logic [dqwc_pkg::OUT_DATA_W-1:0] word);
            t_counters want;
            if (expected_counters.size() == 0) begin
                $error("result arrived with no request outstanding: %h", word);
                errors++;
                return;
            end
            want = expected_counters.pop_front();
            compare("position_left", $signed(want.position_left), $signed(word[15:0]));
            compare("position_right", $signed(want.position_right), $signed(word[31:16]));
            compare("wheel_difference", $signed(want.wheel_difference), $signed(word[47:32]));
            compare("speed_left", $signed(want.speed_left), $signed(word[55:48]));
            compare("speed_right", $signed(want.speed_right), $signed(word[63:56]));
            compare("trigger_left", $signed(want.trigger_left), $signed(word[79:64]));
            compare("trigger_right", $signed(want.trigger_right), $signed(word[95:80]));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [1:0] wheel, [2] sensor, [3] pin_a, [4] pin_b, [20:5] value, [23:21] zero
    logic [dqwc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] opcode
    logic [dqwc_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [15:0] position_left, [31:16] position_right, [47:32] wheel_difference,
    // [55:48] speed_left, [63:56] speed_right, [79:64] trigger_left,
    // [95:80] trigger_right
    logic [dqwc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    counter_tracker tracker = new();

    // Sender and receiver behavior, changed by the main sequence per phase.
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    int unsigned receiver_hold_cycles = 0;
    int unsigned cycle_count = 0;

    // Per-wheel encoder model used to produce clean quadrature motion.
    logic [1:0]  enc_phase[2] = '{default: '0};
    bit          enc_forward[2] = '{default: 1'b1};
    int unsigned enc_run[2] = '{default: 0};

    dual_quadrature_wheel_counter #(
        .SPEED_LIMIT (SPEED_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a correct run ends far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Both handshakes are sampled at the clock edge, before any of this
    // step's nonblocking updates land, so the request is noted before a
    // result of the same edge is checked. A result never belongs to a request
    // accepted at the same edge, as that request first enters the command queue.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_request(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[2],
                                 s_axis_tdata[3], s_axis_tdata[4], s_axis_tdata[20:5]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_counters(m_axis_tdata);
    end

    // Receiver: ready runs broken by short stalls, plain ready when stalls
    // are off, and one long hold-off on request so that the command queue
    // fills and the block has to stall its input.
    initial begin
        int unsigned stall;
        forever begin
            if (receiver_hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (receiver_hold_cycles) @(posedge i_clk);
                receiver_hold_cycles = 0;
            end else if (!receiver_stalls) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                stall = $urandom_range(0, 5);
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted. The
    // valid stays high on return, so back-to-back calls form a burst.
    task automatic send_request(logic [2:0] op, logic [1:0] wheel, logic sensor,
                                logic pin_a, logic pin_b,
                                logic [dqwc_pkg::COUNT_W-1:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, value, pin_b, pin_a, sensor, wheel};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    // Drops valid for a number of cycles; called only with a count of one or more.
    task automatic pause_sender(int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 3'($urandom);
        s_axis_tdata <= dqwc_pkg::IN_DATA_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // One step of clean motion on a wheel: advance the Gray-coded phase in
    // the wheel's current direction and report which line toggled. Runs
    // are mostly short, with an occasional long run that saturates the
    // speed sum.
    task automatic send_motion(logic [1:0] wheel);
        logic [1:0] old_pins;
        logic [1:0] new_pins;
        int         w;
        w = int'(wheel);
        if (enc_run[w] == 0) begin
            enc_forward[w] = 1'($urandom_range(0, 1));
            enc_run[w] = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                     : $urandom_range(1, 20);
        end
        enc_run[w]--;
        // Phase to {A, B}: 00, 01, 11, 10, so each step toggles one line.
        old_pins = {enc_phase[w][1], enc_phase[w][1] ^ enc_phase[w][0]};
        enc_phase[w] = enc_forward[w] ? enc_phase[w] + 2'd1 : enc_phase[w] - 2'd1;
        new_pins = {enc_phase[w][1], enc_phase[w][1] ^ enc_phase[w][0]};
        send_request(dqwc_pkg::OP_EDGE, wheel, old_pins[0] != new_pins[0],
                     new_pins[1], new_pins[0], dqwc_pkg::COUNT_W'($urandom));
    endtask

    // A trigger value: mostly small so that it reaches zero, sometimes any
    // 16-bit pattern including negative ones.
    function automatic logic [dqwc_pkg::COUNT_W-1:0] pick_trigger();
        if ($urandom_range(0, 3) == 0)
            return dqwc_pkg::COUNT_W'($urandom);
        return dqwc_pkg::COUNT_W'($urandom_range(0, 25));
    endfunction

    // One random request: mostly clean encoder motion, some raw edges with
    // any wheel code and pin levels, and the commands at lower rates.
    task automatic send_random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_motion($urandom_range(0, 1) ? dqwc_pkg::SIDE_RIGHT : dqwc_pkg::SIDE_LEFT);
        else if (pick < 78)
            send_request(dqwc_pkg::OP_EDGE, 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), dqwc_pkg::COUNT_W'($urandom));
        else if (pick < 83)
            send_request(dqwc_pkg::OP_CLR_POS, 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), dqwc_pkg::COUNT_W'($urandom));
        else if (pick < 88)
            send_request(dqwc_pkg::OP_WR_DIFF, 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), dqwc_pkg::COUNT_W'($urandom));
        else if (pick < 95)
            send_request(dqwc_pkg::OP_LD_TRIG, 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), pick_trigger());
        else if (pick < 98)
            send_request(dqwc_pkg::OP_CLR_SPEED, 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), dqwc_pkg::COUNT_W'($urandom));
        else
            send_request(dqwc_pkg::OP_CLR_SPEED + 3'($urandom_range(1, 3)), 2'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom),
                         dqwc_pkg::COUNT_W'($urandom));
    endtask

    initial begin
        int unsigned burst_left;
        int unsigned k;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, sent back to back.
        // Every direction rule on both wheels: A edge with equal and unequal
        // levels, then B edge with equal and unequal levels.
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b1, 1'b1, 16'hffff);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b1, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b1, 1'b0, 1'b0, 16'h5555);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b1, 1'b0, 1'b1, 16'haaaa);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_RIGHT, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_RIGHT, 1'b0, 1'b0, 1'b1, 16'hffff);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_RIGHT, 1'b1, 1'b1, 1'b1, 16'h1234);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_RIGHT, 1'b1, 1'b1, 1'b0, 16'hedcb);
        // A trigger counts down to zero and then stays there.
        send_request(dqwc_pkg::OP_LD_TRIG, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b0, 1'b0, 16'd2);
        repeat (3)
            send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b1, 1'b1, 16'h0000);
        // A negative trigger wraps from the most negative value to the most
        // positive one on the next edge.
        send_request(dqwc_pkg::OP_LD_TRIG, dqwc_pkg::SIDE_RIGHT, 1'b1, 1'b1, 1'b1, 16'h8000);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_RIGHT, 1'b0, 1'b0, 1'b0, 16'h0000);
        // Difference writes ignore the wheel code; the maximum wraps on a left
        // up count.
        send_request(dqwc_pkg::OP_WR_DIFF, SIDE_NONE, 1'b1, 1'b1, 1'b1, 16'h7fff);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_WR_DIFF, dqwc_pkg::SIDE_PAIR, 1'b0, 1'b0, 1'b0, 16'h8000);
        // Wheel codes that edges, trigger loads and speed clears ignore, then speed clears on each wheel.
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_PAIR, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_request(dqwc_pkg::OP_EDGE, SIDE_NONE, 1'b1, 1'b0, 1'b1, 16'h0000);
        send_request(dqwc_pkg::OP_LD_TRIG, SIDE_NONE, 1'b0, 1'b0, 1'b0, 16'h1234);
        send_request(dqwc_pkg::OP_CLR_SPEED, dqwc_pkg::SIDE_PAIR, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_CLR_SPEED, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_CLR_SPEED, dqwc_pkg::SIDE_RIGHT, 1'b0, 1'b0, 1'b0, 16'h0000);
        // Position clears on one wheel, on both, and the ignored code.
        send_request(dqwc_pkg::OP_CLR_POS, dqwc_pkg::SIDE_LEFT, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_EDGE, dqwc_pkg::SIDE_LEFT, 1'b1, 1'b1, 1'b1, 16'h0000);
        send_request(dqwc_pkg::OP_CLR_POS, SIDE_NONE, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_CLR_POS, dqwc_pkg::SIDE_RIGHT, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_request(dqwc_pkg::OP_CLR_POS, dqwc_pkg::SIDE_PAIR, 1'b0, 1'b0, 1'b0, 16'h0000);
        // Opcodes past the defined set change nothing but still answer.
        for (k = 1; k <= 3; k++)
            send_request(dqwc_pkg::OP_CLR_SPEED + 3'(k), 2'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), dqwc_pkg::COUNT_W'($urandom));

        // Random part. Phases: both sides idling, then a stretch with no
        // idling on either side, then idling again with one long hold-off
        // of the receiver while the sender keeps offering requests.
        burst_left = 0;
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k == 500) begin
                sender_gaps = 1'b0;
                receiver_stalls = 1'b0;
            end else if (k == 800) begin
                sender_gaps = 1'b1;
                receiver_stalls = 1'b1;
            end else if (k == 1000) begin
                receiver_hold_cycles = LONG_HOLD_CYCLES;
                burst_left = 60;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if (sender_gaps)
                    pause_sender($urandom_range(1, 8));
            end
            burst_left--;
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.expected_counters.size() != 0)
            @(posedge i_clk);
        // Any stray result in these cycles is caught as unexpected.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
